/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and the key compare for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Queue geometry
  localparam int DEPTH      = 16;
  localparam int NAME_BYTES = 8;

  // Field widths
  localparam int PRI_W  = 32;
  localparam int NAME_W = 64;
  localparam int OCC_W  = 5;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Only the low NAME_BYTES bytes of a name take part
  localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);

  // Operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // One queue slot
  typedef struct packed {
    logic                     valid;
    logic signed [PRI_W-1:0]  pri;
    logic        [NAME_W-1:0] name;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_cmd_t;

  // True when key (pa, na) orders at or before key (pb, nb)
  function automatic logic key_le(logic signed [PRI_W-1:0] pa, logic [NAME_W-1:0] na,
                                  logic signed [PRI_W-1:0] pb, logic [NAME_W-1:0] nb);
    logic res;
    if (pa != pb) begin
      res = (pa < pb);
    end else begin
      res = (na <= nb);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares its key with the incoming entry and
// keeps, takes the new entry, or takes a neighbour's entry each transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spq_pkg::cell_cmd_t cmd_i,
  input  wire spq_pkg::entry_t    new_i,
  input  wire spq_pkg::entry_t    left_i,
  input  wire logic               left_le_i,
  input  wire spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t         entry_o,
  output logic                    le_o
);

  logic                              valid_q;
  logic signed [spq_pkg::PRI_W-1:0]  pri_q;
  logic        [spq_pkg::NAME_W-1:0] name_q;
  spq_pkg::entry_t                   entry_d;

  assign entry_o = '{valid: valid_q, pri: pri_q, name: name_q};

  // Slot holds a key at or before the incoming one
  assign le_o = valid_q & spq_pkg::key_le(pri_q, name_q, new_i.pri, new_i.name);

  // Choose next slot content: keep, insert here, shift right or shift left
  always_comb begin
    entry_d = entry_o;
    if (cmd_i.push) begin
      if (!le_o) begin
        if (left_le_i) begin
          entry_d = new_i;
        end else begin
          entry_d = left_i;
        end
      end
    end else if (cmd_i.pop) begin
      entry_d = right_i;
    end
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  // Key payload
  always_ff @(posedge clk_i) begin
    pri_q  <= entry_d.pri;
    name_q <= entry_d.name;
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted chain of slot cells.
// ----------------------------------------------------------------------------
// Takes one operation per clock and returns its result from an output
// register; a result waiting under stall blocks only the next input until it
// is taken. Every cell compares its key with the incoming entry in parallel;
// the cells from the insertion point on (on a dequeue, every cell) shift by
// one slot in that same cycle, so the compare-and-shift of a cell sets the
// rate. Slot 0 always holds the lowest key; equal keys keep arrival order.
`default_nettype none

module sorted_priority_queue (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 func_i,
  input  wire logic signed [spq_pkg::PRI_W-1:0]     in_priority_i,
  input  wire logic        [spq_pkg::NAME_W-1:0]    in_name_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic             [1:0]                    status_o,
  output logic signed      [spq_pkg::PRI_W-1:0]     out_priority_o,
  output logic             [spq_pkg::NAME_W-1:0]    out_name_o,
  output logic             [spq_pkg::OCC_W-1:0]     occupancy_o
);

  localparam spq_pkg::entry_t EMPTY_ENTRY = '0;

  spq_pkg::entry_t            cell_entry [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]  cell_le;
  spq_pkg::entry_t            new_entry;
  spq_pkg::cell_cmd_t         cmd;

  logic [spq_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       accept, full, empty;

  logic                                out_valid_q;
  spq_pkg::status_e                    status_q, status_d;
  logic signed [spq_pkg::PRI_W-1:0]    pri_q, pri_d;
  logic        [spq_pkg::NAME_W-1:0]   name_q, name_d;
  logic        [spq_pkg::OCC_W-1:0]    occ_q;

  // Accept while the output register is free or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign full  = (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign empty = (count_q == '0);

  assign cmd.push = accept & (func_i == spq_pkg::FUNC_ENQ) & ~full;
  assign cmd.pop  = accept & (func_i == spq_pkg::FUNC_DEQ) & ~empty;

  assign new_entry.valid = 1'b1;
  assign new_entry.pri   = in_priority_i;
  assign new_entry.name  = in_name_i & spq_pkg::NAME_MASK;

  // Chain of slot cells
  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry, right_entry;
    logic            left_le;

    if (i == 0) begin : g_head
      assign left_entry = EMPTY_ENTRY;
      assign left_le    = 1'b1;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign right_entry = EMPTY_ENTRY;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .new_i     (new_entry),
      .left_i    (left_entry),
      .left_le_i (left_le),
      .right_i   (right_entry),
      .entry_o   (cell_entry[i]),
      .le_o      (cell_le[i])
    );
  end

  // Work out the result of the accepted operation
  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::STAT_DONE;
    pri_d    = '0;
    name_d   = '0;
    if (func_i == spq_pkg::FUNC_ENQ) begin
      if (full) begin
        status_d = spq_pkg::STAT_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::STAT_EMPTY;
      end else begin
        count_d = count_q - 1'b1;
        pri_d   = cell_entry[0].pri;
        name_d  = cell_entry[0].name;
      end
    end
  end

  // Entry count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pri_q    <= pri_d;
      name_q   <= name_d;
      occ_q    <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = pri_q;
  assign out_name_o     = name_q;
  assign occupancy_o    = occ_q;

endmodule

`default_nettype wire

/* hw/rtl/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic        [1:0]                 status_o,
  input wire logic signed [spq_pkg::PRI_W-1:0]  out_priority_o,
  input wire logic        [spq_pkg::NAME_W-1:0] out_name_o,
  input wire logic        [spq_pkg::OCC_W-1:0]  occupancy_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(out_priority_o) && $stable(out_name_o) && $stable(occupancy_o))
    else $error("stalled result changed");

  // Empty report leaves nothing held
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::STAT_EMPTY |-> occupancy_o == '0)
    else $error("empty status with nonzero occupancy");

  // Full report leaves every slot held
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::STAT_FULL |->
      occupancy_o == spq_pkg::OCC_W'(spq_pkg::DEPTH))
    else $error("full status with queue not full");

  // Refused operations return a zero entry
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != spq_pkg::STAT_DONE |->
      out_priority_o == '0 && out_name_o == '0)
    else $error("refused operation returned an entry");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .out_priority_o (out_priority_o),
  .out_name_o     (out_name_o),
  .occupancy_o    (occupancy_o)
);

`default_nettype wire
